// ===== rtl/core/json_token_lexer_unit_assert.svh =====
// Assertion macros used by the lexer checker.
`ifndef JSON_TOKEN_LEXER_UNIT_ASSERT_SVH
`define JSON_TOKEN_LEXER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JTL_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define JTL_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jtl_pkg.sv =====
package jtl_pkg;

	localparam int POS_BITS = 32;
	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_STR  = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_NUM  = 3'd3,
		MODE_KEY  = 3'd4,
		MODE_BAD  = 3'd5
	} mode_t;

	localparam logic [3:0] KIND_UNDEF    = 4'd0;
	localparam logic [3:0] KIND_LBRACE   = 4'd1;
	localparam logic [3:0] KIND_RBRACE   = 4'd2;
	localparam logic [3:0] KIND_LBRACKET = 4'd3;
	localparam logic [3:0] KIND_RBRACKET = 4'd4;
	localparam logic [3:0] KIND_COMMA    = 4'd5;
	localparam logic [3:0] KIND_COLON    = 4'd6;
	localparam logic [3:0] KIND_STRING   = 4'd7;
	localparam logic [3:0] KIND_NUMBER   = 4'd8;
	localparam logic [3:0] KIND_TRUE     = 4'd9;
	localparam logic [3:0] KIND_FALSE    = 4'd10;
	localparam logic [3:0] KIND_NULL     = 4'd11;
	localparam logic [3:0] KIND_END      = 4'd12;
	localparam logic [3:0] KIND_UNTERM   = 4'd13;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LC_F     = 8'h66;
	localparam logic [7:0] CH_LC_N     = 8'h6E;
	localparam logic [7:0] CH_LC_T     = 8'h74;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] start;
		logic [31:0] length;
		logic        run_end;
	} token_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	typedef struct packed {
		logic   avail;
		token_t tok;
	} qhead_t;

	function automatic logic is_ws(logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic logic [2:0] kw_len(logic [1:0] c);
		return (c == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [3:0] kw_kind(logic [1:0] c);
		logic [3:0] k;
		k = KIND_UNDEF;
		unique case (c)
			KW_TRUE:  k = KIND_TRUE;
			KW_FALSE: k = KIND_FALSE;
			KW_NULL:  k = KIND_NULL;
			default:  k = KIND_UNDEF;
		endcase
		return k;
	endfunction

	// letter i of the chosen keyword
	function automatic logic [7:0] kw_char(logic [1:0] c, logic [2:0] i);
		logic [7:0] r;
		r = CH_NUL;
		unique case ({c, i})
			{KW_TRUE, 3'd0}:  r = 8'h74;
			{KW_TRUE, 3'd1}:  r = 8'h72;
			{KW_TRUE, 3'd2}:  r = 8'h75;
			{KW_TRUE, 3'd3}:  r = 8'h65;
			{KW_FALSE, 3'd0}: r = 8'h66;
			{KW_FALSE, 3'd1}: r = 8'h61;
			{KW_FALSE, 3'd2}: r = 8'h6C;
			{KW_FALSE, 3'd3}: r = 8'h73;
			{KW_FALSE, 3'd4}: r = 8'h65;
			{KW_NULL, 3'd0}:  r = 8'h6E;
			{KW_NULL, 3'd1}:  r = 8'h75;
			{KW_NULL, 3'd2}:  r = 8'h6C;
			{KW_NULL, 3'd3}:  r = 8'h6C;
			default:          r = CH_NUL;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/json_token_lexer_unit.sv =====
// channel  | handshake                 | payload
// text     | text_valid / text_stall   | text_byte
// token    | token_valid / token_stall | token_kind, token_start, token_length, final_of_run
//
// One byte is taken per cycle while the token queue has two free slots.
// A token is written into the token queue and then into the output register.
// Bytes that end a number on a punctuation mark queue two tokens; the output
// drains one per cycle unless stalled; a long run is paced by the output port.
// Reset clears the lexer mode, positions and queue; no clearing pass is needed.
module json_token_lexer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_byte,
	input  logic        text_valid,
	output logic        text_stall,
	output logic [3:0]  token_kind,
	output logic [31:0] token_start,
	output logic [31:0] token_length,
	output logic        final_of_run,
	output logic        token_valid,
	input  logic        token_stall
);

	jtl_pkg::push_t  push;
	jtl_pkg::qhead_t head;
	logic            room;
	logic            pop;

	jtl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.room       (room),
		.push       (push)
	);

	jtl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.pop    (pop),
		.head   (head)
	);

	jtl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.final_of_run (final_of_run)
	);

endmodule

// ===== rtl/core/jtl_front.sv =====
module jtl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      text_byte,
	input  logic            text_valid,
	output logic            text_stall,
	input  logic            room,
	output jtl_pkg::push_t  push
);

	jtl_pkg::mode_t       mode_q, mode_d;
	logic [1:0]           choice_q, choice_d;
	logic [2:0]           matched_q, matched_d;
	jtl_pkg::pos_t        pend_q, pend_d;
	jtl_pkg::pos_t        pos_q;
	jtl_pkg::pos_t        span, span1;

	logic                 acc;
	logic                 is_nul;
	logic                 idle_emit;
	logic [3:0]           idle_kind;
	jtl_pkg::mode_t       idle_mode;
	logic                 idle_open;
	logic                 idle_key;
	logic [1:0]           idle_choice;
	logic                 num_cont, num_end;
	logic                 key_ok, key_done;
	logic [2:0]           matched_inc;

	logic [1:0]           n;
	jtl_pkg::token_t      tok0, tok1;

	assign text_stall  = !room;
	assign acc         = text_valid && room;
	assign is_nul      = text_byte == jtl_pkg::CH_NUL;
	assign span        = pos_q - pend_q;
	assign span1       = span + jtl_pkg::pos_t'(1);
	assign matched_inc = matched_q + 3'd1;

	// classify the byte as the start of a new token
	always_comb begin
		idle_emit   = 1'b1;
		idle_kind   = jtl_pkg::KIND_UNDEF;
		idle_mode   = jtl_pkg::MODE_IDLE;
		idle_open   = 1'b0;
		idle_key    = 1'b0;
		idle_choice = jtl_pkg::KW_TRUE;
		priority if (jtl_pkg::is_ws(text_byte)) begin
			idle_emit = 1'b0;
		end else if (text_byte == jtl_pkg::CH_LBRACE) begin
			idle_kind = jtl_pkg::KIND_LBRACE;
		end else if (text_byte == jtl_pkg::CH_RBRACE) begin
			idle_kind = jtl_pkg::KIND_RBRACE;
		end else if (text_byte == jtl_pkg::CH_LBRACKET) begin
			idle_kind = jtl_pkg::KIND_LBRACKET;
		end else if (text_byte == jtl_pkg::CH_RBRACKET) begin
			idle_kind = jtl_pkg::KIND_RBRACKET;
		end else if (text_byte == jtl_pkg::CH_COMMA) begin
			idle_kind = jtl_pkg::KIND_COMMA;
		end else if (text_byte == jtl_pkg::CH_COLON) begin
			idle_kind = jtl_pkg::KIND_COLON;
		end else if (is_nul) begin
			idle_kind = jtl_pkg::KIND_END;
		end else begin
			idle_emit = 1'b0;
			idle_open = 1'b1;
			if (text_byte == jtl_pkg::CH_QUOTE) begin
				idle_mode = jtl_pkg::MODE_STR;
			end else if (jtl_pkg::is_digit(text_byte) || text_byte == jtl_pkg::CH_MINUS) begin
				idle_mode = jtl_pkg::MODE_NUM;
			end else if (text_byte == jtl_pkg::CH_LC_T) begin
				idle_mode = jtl_pkg::MODE_KEY;
				idle_key  = 1'b1;
			end else if (text_byte == jtl_pkg::CH_LC_F) begin
				idle_mode   = jtl_pkg::MODE_KEY;
				idle_key    = 1'b1;
				idle_choice = jtl_pkg::KW_FALSE;
			end else if (text_byte == jtl_pkg::CH_LC_N) begin
				idle_mode   = jtl_pkg::MODE_KEY;
				idle_key    = 1'b1;
				idle_choice = jtl_pkg::KW_NULL;
			end else begin
				idle_mode = jtl_pkg::MODE_BAD;
			end
		end
	end

	assign num_cont = jtl_pkg::is_digit(text_byte) || text_byte == jtl_pkg::CH_MINUS
		|| text_byte == jtl_pkg::CH_DOT;
	assign num_end  = is_nul || jtl_pkg::is_ws(text_byte) || text_byte == jtl_pkg::CH_COMMA
		|| text_byte == jtl_pkg::CH_RBRACE || text_byte == jtl_pkg::CH_RBRACKET;
	assign key_ok   = choice_q != 2'd3 && matched_q < jtl_pkg::kw_len(choice_q)
		&& text_byte == jtl_pkg::kw_char(choice_q, matched_q);
	assign key_done = matched_inc == jtl_pkg::kw_len(choice_q);

	// next state
	always_comb begin
		mode_d    = mode_q;
		choice_d  = choice_q;
		matched_d = matched_q;
		pend_d    = pend_q;
		unique case (mode_q)
			jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC: begin
				if (is_nul) begin
					mode_d = jtl_pkg::MODE_IDLE;
				end else if (mode_q == jtl_pkg::MODE_ESC) begin
					mode_d = jtl_pkg::MODE_STR;
				end else if (text_byte == jtl_pkg::CH_BSLASH) begin
					mode_d = jtl_pkg::MODE_ESC;
				end else if (text_byte == jtl_pkg::CH_QUOTE) begin
					mode_d = jtl_pkg::MODE_IDLE;
				end
			end
			jtl_pkg::MODE_NUM: begin
				if (num_cont) begin
					mode_d = mode_q;
				end else if (num_end) begin
					mode_d = idle_mode;
					if (idle_open) pend_d = pos_q;
					if (idle_key) begin
						choice_d  = idle_choice;
						matched_d = 3'd1;
					end
				end else begin
					mode_d = jtl_pkg::MODE_BAD;
				end
			end
			jtl_pkg::MODE_KEY: begin
				if (key_ok) begin
					matched_d = matched_inc;
					if (key_done) mode_d = jtl_pkg::MODE_IDLE;
				end else if (is_nul) begin
					mode_d = jtl_pkg::MODE_IDLE;
				end else begin
					mode_d = jtl_pkg::MODE_BAD;
				end
			end
			jtl_pkg::MODE_BAD: begin
				if (is_nul) mode_d = jtl_pkg::MODE_IDLE;
			end
			default: begin
				mode_d = idle_mode;
				if (idle_open) pend_d = pos_q;
				if (idle_key) begin
					choice_d  = idle_choice;
					matched_d = 3'd1;
				end
			end
		endcase
		if (is_nul) mode_d = jtl_pkg::MODE_IDLE;
	end

	// emitted tokens
	always_comb begin
		n    = 2'd0;
		tok0 = '{kind: jtl_pkg::KIND_UNDEF, start: 32'(pend_q), length: 32'(span),
			run_end: 1'b0};
		tok1 = '{kind: jtl_pkg::KIND_END, start: 32'(pos_q), length: 32'd1, run_end: 1'b1};
		unique case (mode_q)
			jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC: begin
				if (is_nul) begin
					n         = 2'd2;
					tok0.kind = jtl_pkg::KIND_UNTERM;
				end else if (mode_q == jtl_pkg::MODE_STR && text_byte == jtl_pkg::CH_QUOTE) begin
					n           = 2'd1;
					tok0.kind   = jtl_pkg::KIND_STRING;
					tok0.length = 32'(span1);
				end
			end
			jtl_pkg::MODE_NUM: begin
				if (!num_cont && num_end) begin
					tok0.kind = jtl_pkg::KIND_NUMBER;
					tok1.kind = idle_kind;
					n         = idle_emit ? 2'd2 : 2'd1;
				end
			end
			jtl_pkg::MODE_KEY: begin
				if (key_ok) begin
					if (key_done) begin
						n           = 2'd1;
						tok0.kind   = jtl_pkg::kw_kind(choice_q);
						tok0.length = 32'(span1);
					end
				end else if (is_nul) begin
					n = 2'd2;
				end
			end
			jtl_pkg::MODE_BAD: begin
				if (is_nul) n = 2'd2;
			end
			default: begin
				if (idle_emit) begin
					n           = 2'd1;
					tok0.kind   = idle_kind;
					tok0.start  = 32'(pos_q);
					tok0.length = 32'd1;
				end
			end
		endcase
		tok0.run_end = n == 2'd1;
	end

	assign push.n    = acc ? n : 2'd0;
	assign push.tok0 = tok0;
	assign push.tok1 = tok1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jtl_pkg::MODE_IDLE;
			choice_q  <= jtl_pkg::KW_TRUE;
			matched_q <= 3'd0;
			pend_q    <= '0;
			pos_q     <= '0;
		end else if (acc) begin
			mode_q    <= mode_d;
			choice_q  <= choice_d;
			matched_q <= matched_d;
			pend_q    <= pend_d;
			pos_q     <= is_nul ? '0 : pos_q + jtl_pkg::pos_t'(1);
		end
	end

endmodule

// ===== rtl/core/jtl_queue.sv =====
module jtl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  jtl_pkg::push_t  push,
	output logic            room,
	input  logic            pop,
	output jtl_pkg::qhead_t head
);

	jtl_pkg::token_t             entries_q [jtl_pkg::QDEPTH];
	logic [jtl_pkg::QAW-1:0]     wr_q, rd_q;
	logic [jtl_pkg::QCW-1:0]     cnt_q;
	logic [jtl_pkg::QAW-1:0]     wr_next;

	assign wr_next    = wr_q + jtl_pkg::QAW'(1);
	// keep space for the two tokens one byte can cause
	assign room       = cnt_q <= jtl_pkg::QCW'(jtl_pkg::QDEPTH - 2);
	assign head.avail = cnt_q != '0;
	assign head.tok   = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) entries_q[wr_q] <= push.tok0;
		if (push.n == 2'd2) entries_q[wr_next] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + jtl_pkg::QAW'(push.n);
			rd_q  <= rd_q + jtl_pkg::QAW'(pop);
			cnt_q <= cnt_q + jtl_pkg::QCW'(push.n) - jtl_pkg::QCW'(pop);
		end
	end

endmodule

// ===== rtl/core/jtl_back.sv =====
module jtl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jtl_pkg::qhead_t head,
	output logic            pop,
	output logic            token_valid,
	input  logic            token_stall,
	output logic [3:0]      token_kind,
	output logic [31:0]     token_start,
	output logic [31:0]     token_length,
	output logic            final_of_run
);

	logic            valid_q;
	jtl_pkg::token_t tok_q;

	assign pop = head.avail && (!valid_q || !token_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!token_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) tok_q <= head.tok;
	end

	assign token_valid  = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign final_of_run = tok_q.run_end;

endmodule

// ===== rtl/core/jtl_checker.sv =====
`include "json_token_lexer_unit_assert.svh"

module jtl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [3:0]  token_kind,
	input logic [31:0] token_start,
	input logic [31:0] token_length,
	input logic        final_of_run,
	input logic        token_valid,
	input logic        token_stall
);

	logic [68:0] tok_word;
	logic        lead_ok;

	assign tok_word = {token_kind, token_start, token_length, final_of_run};
	// only a broken token, a number or a cut-off string can precede another token
	assign lead_ok  = token_kind == jtl_pkg::KIND_UNDEF || token_kind == jtl_pkg::KIND_NUMBER
		|| token_kind == jtl_pkg::KIND_UNTERM;

	`JTL_NEXT(a_valid_holds, token_valid && token_stall, token_valid, "token dropped while stalled")
	`JTL_NEXT(a_word_holds, token_valid && token_stall, $stable(tok_word), "stalled token changed")
	`JTL_IMPLIES(a_kind_range, token_valid, token_kind <= jtl_pkg::KIND_UNTERM, "kind out of range")
	`JTL_IMPLIES(a_end_shape, token_valid && token_kind == jtl_pkg::KIND_END, token_length == 32'd1 && final_of_run, "bad end token")
	`JTL_IMPLIES(a_lead_kind, token_valid && !final_of_run, lead_ok, "unexpected leading token")

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (.*);
